@@ design/sphcc_pkg.sv @@
package sphcc_pkg;

  localparam int unsigned HeaderBytes    = 6;
  localparam int unsigned PosWidth       = 3;
  localparam int unsigned CaptureBytes   = 4;
  localparam int unsigned CaptureWidth   = 8 * CaptureBytes;
  localparam int unsigned QueueDepthDflt = 2;

  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [2:0]  VersionNoCrc = 3'd3;

  // One finished packet as handed from the front to the back.
  typedef struct packed {
    logic [CaptureWidth-1:0] hdr;
    logic                    crc_zero;
    logic                    too_short;
  } sphcc_rec_t;

  // CRC-16/CCITT over one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ design/space_packet_header_crc_checker.sv @@
// Throughput: one byte per cycle while the queue is not full; header capture and the
// byte-wide CRC update happen in the same cycle. The queue is written at the edge that
// accepts a packet's last byte; the output register takes it when empty or draining.
// The queue holds QueueDepth finished packets; input stalls only when it is full.
// Reset (rst_ni low, async): CRC to 0xFFFF, byte position and header to zero,
// queue empty, no result valid.
module space_packet_header_crc_checker
  import sphcc_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDflt
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  version_number_o,
  output logic        packet_type_o,
  output logic        secondary_header_present_o,
  output logic [10:0] application_id_o,
  output logic [1:0]  sequence_flags_o,
  output logic [13:0] sequence_count_o,
  output logic        crc_checked_o,
  output logic        crc_good_o,
  output logic        too_short_o,
  output logic        packet_bad_o
);

  sphcc_rec_t front_rec, back_rec;
  logic       push, q_full, q_valid, pop;

  sphcc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .last_byte_i  (last_byte_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .rec_o        (front_rec)
  );

  sphcc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rec_o   (back_rec)
  );

  sphcc_back u_back (
    .clk_i                      (clk_i),
    .rst_ni                     (rst_ni),
    .q_valid_i                  (q_valid),
    .rec_i                      (back_rec),
    .pop_o                      (pop),
    .out_valid_o                (out_valid_o),
    .out_ready_i                (out_ready_i),
    .version_number_o           (version_number_o),
    .packet_type_o              (packet_type_o),
    .secondary_header_present_o (secondary_header_present_o),
    .application_id_o           (application_id_o),
    .sequence_flags_o           (sequence_flags_o),
    .sequence_count_o           (sequence_count_o),
    .crc_checked_o              (crc_checked_o),
    .crc_good_o                 (crc_good_o),
    .too_short_o                (too_short_o),
    .packet_bad_o               (packet_bad_o)
  );

  a_bad_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (packet_bad_o ==
      (too_short_o || packet_type_o || (crc_checked_o && !crc_good_o))))
    else $error("packet verdict inconsistent with flags");

  a_crc_applies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (crc_checked_o == (version_number_o != VersionNoCrc)))
    else $error("crc_checked does not follow version");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("packet pushed into full queue");

  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o)
    else $error("popped packet did not reach output");

endmodule

@@ design/sphcc_front.sv @@
module sphcc_front
  import sphcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_value_i,
  input  logic       last_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output sphcc_rec_t rec_o
);

  logic [PosWidth-1:0]     pos_q, pos_d;
  logic [CaptureWidth-1:0] hdr_q, hdr_d;
  logic [15:0]             crc_q, crc_d;
  logic                    accept;
  logic [PosWidth-1:0]     pos_next;
  logic [CaptureWidth-1:0] hdr_next;
  logic [15:0]             crc_next;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    crc_next = crc_byte(crc_q, byte_value_i);
    hdr_next = hdr_q;
    pos_next = pos_q;
    if (pos_q < PosWidth'(HeaderBytes)) begin
      pos_next = pos_q + PosWidth'(1);
    end
    // Only the first words carry decoded fields; later header bytes just count.
    for (int k = 0; k < CaptureBytes; k++) begin
      if (pos_q == PosWidth'(k)) begin
        hdr_next[CaptureWidth-1-8*k -: 8] = byte_value_i;
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    hdr_d = hdr_q;
    crc_d = crc_q;
    if (accept) begin
      if (last_byte_i) begin
        pos_d = '0;
        hdr_d = '0;
        crc_d = CrcInit;
      end else begin
        pos_d = pos_next;
        hdr_d = hdr_next;
        crc_d = crc_next;
      end
    end
  end

  assign push_o          = accept && last_byte_i;
  assign rec_o.hdr       = hdr_next;
  assign rec_o.crc_zero  = (crc_next == 16'h0000);
  assign rec_o.too_short = (pos_next < PosWidth'(HeaderBytes));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hdr_q <= '0;
      crc_q <= CrcInit;
    end else begin
      pos_q <= pos_d;
      hdr_q <= hdr_d;
      crc_q <= crc_d;
    end
  end

endmodule

@@ design/sphcc_queue.sv @@
module sphcc_queue
  import sphcc_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDflt
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sphcc_rec_t rec_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       pop_i,
  output sphcc_rec_t rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sphcc_rec_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ design/sphcc_back.sv @@
module sphcc_back
  import sphcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  sphcc_rec_t  rec_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  version_number_o,
  output logic        packet_type_o,
  output logic        secondary_header_present_o,
  output logic [10:0] application_id_o,
  output logic [1:0]  sequence_flags_o,
  output logic [13:0] sequence_count_o,
  output logic        crc_checked_o,
  output logic        crc_good_o,
  output logic        too_short_o,
  output logic        packet_bad_o
);

  logic        valid_q, valid_d;
  logic [2:0]  ver_q;
  logic        type_q, sec_q, chk_q, good_q, short_q, bad_q;
  logic [10:0] apid_q;
  logic [1:0]  flags_q;
  logic [13:0] count_q;
  logic [15:0] w1, w2;
  logic        chk;

  assign w1  = rec_i.hdr[31:16];
  assign w2  = rec_i.hdr[15:0];
  assign chk = (w1[15:13] != VersionNoCrc);

  // Take a new record whenever the output register is empty or draining.
  assign pop_o   = q_valid_i && (!valid_q || out_ready_i);
  assign valid_d = pop_o ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ver_q   <= w1[15:13];
      type_q  <= w1[12];
      sec_q   <= w1[11];
      apid_q  <= w1[10:0];
      flags_q <= w2[15:14];
      count_q <= w2[13:0];
      chk_q   <= chk;
      good_q  <= rec_i.crc_zero;
      short_q <= rec_i.too_short;
      bad_q   <= rec_i.too_short || w1[12] || (chk && !rec_i.crc_zero);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o                = valid_q;
  assign version_number_o           = ver_q;
  assign packet_type_o              = type_q;
  assign secondary_header_present_o = sec_q;
  assign application_id_o           = apid_q;
  assign sequence_flags_o           = flags_q;
  assign sequence_count_o           = count_q;
  assign crc_checked_o              = chk_q;
  assign crc_good_o                 = good_q;
  assign too_short_o                = short_q;
  assign packet_bad_o               = bad_q;

endmodule

@@ test/space_packet_header_crc_checker_tb.sv @@
`timescale 1ns / 1ps

module space_packet_header_crc_checker_tb;
  import sphcc_pkg::*;

  typedef struct packed {
    logic [2:0]  version;
    logic        ptype;
    logic        sec_hdr;
    logic [10:0] apid;
    logic [1:0]  seq_flags;
    logic [13:0] seq_count;
    logic        crc_checked;
    logic        crc_good;
    logic        too_short;
    logic        bad;
  } header_verdict_t;

  // Where a directed byte comes from: the table itself, or the high byte of the running CRC.
  typedef enum logic {
    SRC_LIT,
    SRC_CRC
  } byte_src_e;

  typedef struct packed {
    byte_src_e       src;
    logic [7:0]      value;
    logic            last;
    logic            typed;
    header_verdict_t want;
  } feed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_value_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  version_number_o;
  logic        packet_type_o;
  logic        secondary_header_present_o;
  logic [10:0] application_id_o;
  logic [1:0]  sequence_flags_o;
  logic [13:0] sequence_count_o;
  logic        crc_checked_o;
  logic        crc_good_o;
  logic        too_short_o;
  logic        packet_bad_o;

  space_packet_header_crc_checker DUT (
    .clk_i                      (clk_i),
    .rst_ni                     (rst_ni),
    .in_valid_i                 (in_valid_i),
    .in_ready_o                 (in_ready_o),
    .byte_value_i               (byte_value_i),
    .last_byte_i                (last_byte_i),
    .out_valid_o                (out_valid_o),
    .out_ready_i                (out_ready_i),
    .version_number_o           (version_number_o),
    .packet_type_o              (packet_type_o),
    .secondary_header_present_o (secondary_header_present_o),
    .application_id_o           (application_id_o),
    .sequence_flags_o           (sequence_flags_o),
    .sequence_count_o           (sequence_count_o),
    .crc_checked_o              (crc_checked_o),
    .crc_good_o                 (crc_good_o),
    .too_short_o                (too_short_o),
    .packet_bad_o               (packet_bad_o)
  );

  // Predictor state, mirrors the block's packet front end.
  logic [PosWidth-1:0] hdr_count = '0;
  logic [47:0]         hdr_bits = '0;
  logic [15:0]         crc_reg = CrcInit;

  header_verdict_t pending_verdicts[$];
  int unsigned     mismatches = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     idle_pct = 0;
  int unsigned     stall_pct = 0;

  int unsigned idle_by_phase[4]  = '{0, 62, 0, 33};
  int unsigned stall_by_phase[4] = '{0, 0, 62, 33};

  // Two CRC rows in a row always leave a zero residue.
  feed_row_t directed_rows[24] = '{
    '{SRC_LIT, 8'h00, 1'b1, 1'b0, '0},
    '{SRC_LIT, 8'hFF, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'hFF, 1'b1, 1'b1,
      '{3'd7, 1'b1, 1'b1, 11'h7FF, 2'd0, 14'd0, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{SRC_LIT, 8'h00, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'h00, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'h00, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'h00, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'h00, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'h00, 1'b0, 1'b0, '0},
    '{SRC_CRC, 8'h00, 1'b0, 1'b0, '0},
    '{SRC_CRC, 8'h00, 1'b1, 1'b1,
      '{3'd0, 1'b0, 1'b0, 11'h000, 2'd0, 14'd0, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{SRC_LIT, 8'h67, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'hFF, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'hFF, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'hFF, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'h00, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'h07, 1'b1, 1'b0, '0},
    '{SRC_LIT, 8'h08, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'hFF, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'hFF, 1'b0, 1'b0, '0},
    '{SRC_LIT, 8'hFF, 1'b0, 1'b0, '0},
    '{SRC_CRC, 8'h00, 1'b0, 1'b0, '0},
    '{SRC_CRC, 8'h00, 1'b1, 1'b1,
      '{3'd0, 1'b0, 1'b1, 11'h0FF, 2'd3, 14'h3FFF, 1'b1, 1'b1, 1'b0, 1'b0}},
    '{SRC_LIT, 8'h10, 1'b1, 1'b0, '0}
  };

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("space_packet_header_crc_checker_tb NOT OK");
    $finish;
  end

  // Feed the data bits MSB first through the 0x1021 feedback.
  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  task automatic absorb_byte(input logic [7:0] b, input logic last, output logic produced,
                             output header_verdict_t v);
    logic [15:0] w1;
    logic [15:0] w2;
    crc_reg = crc16_next(crc_reg, b);
    if (hdr_count < HeaderBytes) begin
      hdr_bits[47 - 8 * hdr_count -: 8] = b;
      hdr_count++;
    end
    produced = last;
    v = '0;
    if (last) begin
      w1 = hdr_bits[47:32];
      w2 = hdr_bits[31:16];
      v.version     = w1[15:13];
      v.ptype       = w1[12];
      v.sec_hdr     = w1[11];
      v.apid        = w1[10:0];
      v.seq_flags   = w2[15:14];
      v.seq_count   = w2[13:0];
      v.crc_checked = (w1[15:13] != VersionNoCrc);
      v.crc_good    = (crc_reg == 16'h0000);
      v.too_short   = (hdr_count < HeaderBytes);
      v.bad         = v.too_short | v.ptype | (v.crc_checked & ~v.crc_good);
      hdr_count = '0;
      hdr_bits  = '0;
      crc_reg   = CrcInit;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input header_verdict_t want);
    logic            produced;
    header_verdict_t v;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_valid_i   <= 1'b1;
    byte_value_i <= b;
    last_byte_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_byte(b, last, produced, v);
    if (produced) pending_verdicts.push_back(typed ? want : v);
    bytes_sent++;
  endtask

  task automatic send_random_packet();
    int unsigned kind;
    int unsigned body_len;
    logic [7:0]  b;
    kind = $urandom_range(99);
    if (kind < 12) begin
      body_len = $urandom_range(1, HeaderBytes - 1);
      for (int i = 0; i < body_len; i++) send_byte(8'($urandom), i == body_len - 1, 1'b0, '0);
    end else begin
      body_len = ($urandom_range(9) == 0) ? $urandom_range(15, 40) : $urandom_range(4, 10);
      for (int i = 0; i < body_len; i++) begin
        b = 8'($urandom);
        if (i == 0 && $urandom_range(2) == 0) b[7:5] = VersionNoCrc;
        if (i == 0 && $urandom_range(1) == 0) b[4] = 1'b0;
        send_byte(b, 1'b0, 1'b0, '0);
      end
      // Close with the running CRC so the residue lands on zero; corrupt it now and then.
      for (int i = 0; i < 2; i++) begin
        b = crc_reg[15:8];
        if (kind < 25 && i == 1) b ^= 8'($urandom_range(1, 255));
        send_byte(b, i == 1, 1'b0, '0);
      end
    end
  endtask

  // Hold the sender off until every pending verdict has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    header_verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result transfer with no packet pending", $realtime);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("version_number", want.version, version_number_o);
        check_field("packet_type", want.ptype, packet_type_o);
        check_field("secondary_header_present", want.sec_hdr, secondary_header_present_o);
        check_field("application_id", want.apid, application_id_o);
        check_field("sequence_flags", want.seq_flags, sequence_flags_o);
        check_field("sequence_count", want.seq_count, sequence_count_o);
        check_field("crc_checked", want.crc_checked, crc_checked_o);
        check_field("crc_good", want.crc_good, crc_good_o);
        check_field("too_short", want.too_short, too_short_o);
        check_field("packet_bad", want.bad, packet_bad_o);
      end
    end
  end

  initial begin
    int unsigned phase_start;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_byte(directed_rows[r].src == SRC_CRC ? crc_reg[15:8] : directed_rows[r].value,
                directed_rows[r].last, directed_rows[r].typed, directed_rows[r].want);
    end
    drain_results();

    for (int p = 0; p < 4; p++) begin
      idle_pct    = idle_by_phase[p];
      stall_pct   = stall_by_phase[p];
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 108) send_random_packet();
      drain_results();
    end

    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("space_packet_header_crc_checker_tb OK");
    end else begin
      $display("space_packet_header_crc_checker_tb NOT OK");
    end
    $finish;
  end

endmodule
